[hdl/cfd_pkg.sv]
// Shared types, constants and helpers for the checksummed frame deframer.
package cfd_pkg;

    localparam logic [7:0] HDR_BYTE      = 8'h68;
    localparam logic [7:0] END_BYTE      = 8'h16;
    localparam logic [7:0] DECODE_OFFSET = 8'h33;

    localparam logic [7:0] CMD_NORMAL = 8'h04;
    localparam logic [7:0] CMD_INFO   = 8'h02;
    localparam logic [7:0] CMD_TEST   = 8'h05;
    localparam logic [7:0] CMD_RESET  = 8'h10;

    localparam int STAGE_SLOTS = 15;
    localparam int CFG_INDEX_W = 8;

    localparam logic [CFG_INDEX_W-1:0] REG_DEVICE_ADDRESS = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_ADDRESS_CHECK  = 8'd1;

    localparam logic [7:0] DEVICE_ADDRESS_RST = 8'h10;
    localparam logic [7:0] ADDRESS_CHECK_RST  = 8'hEF;

    typedef enum logic [2:0] {
        KIND_NORMAL = 3'd0,
        KIND_INFO   = 3'd1,
        KIND_TEST   = 3'd2,
        KIND_RESET  = 3'd3,
        KIND_ERROR  = 3'd4
    } kind_t;

    typedef struct packed {
        logic [7:0] device_address;
        logic [7:0] address_check;
    } cfg_t;

    typedef struct packed {
        logic [2:0]  frame_kind;
        logic [7:0]  command_code;
        logic [7:0]  payload_length;
        logic [63:0] data_low;
        logic [55:0] data_high;
    } result_t;

    function automatic kind_t kind_of(input logic [7:0] cmd);
        kind_t k;
        unique case (cmd)
            CMD_NORMAL: k = KIND_NORMAL;
            CMD_INFO:   k = KIND_INFO;
            CMD_TEST:   k = KIND_TEST;
            CMD_RESET:  k = KIND_RESET;
            default:    k = KIND_ERROR;
        endcase
        return k;
    endfunction

endpackage

[hdl/cfd_if.sv]
// Stream interfaces for received bytes and decoded frames.
interface cfd_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface cfd_frame_if;
    logic        valid;
    logic        ready;
    logic [2:0]  frame_kind;
    logic [7:0]  command_code;
    logic [7:0]  payload_length;
    logic [63:0] data_low;
    logic [55:0] data_high;

    modport source (output valid, output frame_kind, output command_code,
                    output payload_length, output data_low, output data_high,
                    input ready);
    modport sink   (input valid, input frame_kind, input command_code,
                    input payload_length, input data_low, input data_high,
                    output ready);
endinterface

[hdl/cfd_parser.sv]
// Frame hunting state machine, running checksum and payload staging.
module cfd_parser #(
    parameter int DECODED_BYTES = 15
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              byte_valid,
    input  logic [7:0]        byte_data,
    input  cfd_pkg::cfg_t     cfg,
    output logic              result_valid,
    output cfd_pkg::result_t  result
);
    import cfd_pkg::*;

    localparam int IDX_W = (DECODED_BYTES > 1) ? $clog2(DECODED_BYTES) : 1;

    typedef enum logic [2:0] {
        PH_HEADER, PH_ADDRESS, PH_CHECK, PH_COMMAND,
        PH_LENGTH, PH_PAYLOAD, PH_SUM, PH_END
    } phase_t;

    phase_t     phase_reg;
    logic       address_seen_reg;
    logic [7:0] sum_reg;
    logic [7:0] length_reg;
    logic [7:0] count_reg;
    logic [7:0] command_reg;
    logic [7:0] stage_reg [DECODED_BYTES];

    logic [7:0] count_inc;
    logic [7:0] sum_add;
    logic       frame_start;
    logic       stage_write;
    logic [STAGE_SLOTS*8-1:0] decoded;

    assign count_inc   = count_reg + 8'd1;
    assign sum_add     = sum_reg + byte_data;
    assign frame_start = byte_valid && phase_reg == PH_HEADER && byte_data == HDR_BYTE
                         && !address_seen_reg;
    assign stage_write = byte_valid && phase_reg == PH_PAYLOAD
                         && count_reg < 8'(DECODED_BYTES);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_HEADER;
            address_seen_reg <= 1'b0;
            sum_reg          <= 8'd0;
            length_reg       <= 8'd0;
            count_reg        <= 8'd0;
            command_reg      <= 8'd0;
        end
        else if (byte_valid)
        begin
            unique case (phase_reg)
                PH_HEADER:
                begin
                    if (byte_data == HDR_BYTE)
                    begin
                        if (address_seen_reg)
                        begin
                            // second header of a frame whose address matched
                            address_seen_reg <= 1'b0;
                            sum_reg          <= sum_add;
                            phase_reg        <= PH_COMMAND;
                        end
                        else
                        begin
                            sum_reg   <= HDR_BYTE;
                            phase_reg <= PH_ADDRESS;
                        end
                    end
                    else
                    begin
                        address_seen_reg <= 1'b0;
                    end
                end
                PH_ADDRESS:
                begin
                    if (byte_data == cfg.device_address)
                    begin
                        sum_reg   <= sum_add;
                        phase_reg <= PH_CHECK;
                    end
                    else
                    begin
                        phase_reg <= PH_HEADER;
                    end
                end
                PH_CHECK:
                begin
                    if (byte_data == cfg.address_check)
                    begin
                        sum_reg          <= sum_add;
                        address_seen_reg <= 1'b1;
                    end
                    else
                    begin
                        address_seen_reg <= 1'b0;
                    end
                    phase_reg <= PH_HEADER;
                end
                PH_COMMAND:
                begin
                    command_reg <= byte_data;
                    sum_reg     <= sum_add;
                    phase_reg   <= PH_LENGTH;
                end
                PH_LENGTH:
                begin
                    length_reg <= byte_data;
                    count_reg  <= 8'd0;
                    sum_reg    <= sum_add;
                    phase_reg  <= (byte_data == 8'd0) ? PH_SUM : PH_PAYLOAD;
                end
                PH_PAYLOAD:
                begin
                    sum_reg <= sum_add;
                    if (count_inc == length_reg)
                    begin
                        count_reg <= 8'd0;
                        phase_reg <= PH_SUM;
                    end
                    else
                    begin
                        count_reg <= count_inc;
                    end
                end
                PH_SUM:
                begin
                    phase_reg <= (byte_data == sum_reg) ? PH_END : PH_HEADER;
                end
                PH_END:
                begin
                    phase_reg <= PH_HEADER;
                end
                default:
                begin
                    phase_reg <= PH_HEADER;
                end
            endcase
        end
    end

    // Staging bytes: clear on frame start, fill from the payload.
    always_ff @(posedge clk)
    begin
        if (frame_start)
        begin
            for (int i = 0; i < DECODED_BYTES; i++)
            begin
                stage_reg[i] <= 8'd0;
            end
        end
        else if (stage_write)
        begin
            stage_reg[count_reg[IDX_W-1:0]] <= byte_data;
        end
    end

    for (genvar k = 0; k < STAGE_SLOTS; k++)
    begin : g_decode
        if (k < DECODED_BYTES)
        begin : g_used
            assign decoded[k*8 +: 8] = stage_reg[k] - DECODE_OFFSET;
        end
        else
        begin : g_unused
            assign decoded[k*8 +: 8] = 8'd0;
        end
    end

    assign result_valid          = byte_valid && phase_reg == PH_END && byte_data == END_BYTE;
    assign result.frame_kind     = kind_of(command_reg);
    assign result.command_code   = command_reg;
    assign result.payload_length = length_reg;
    assign result.data_low       = decoded[63:0];
    assign result.data_high      = decoded[119:64];

endmodule

[hdl/cfd_out_buf.sv]
// Two-entry output buffer: result register plus a skid slot.
module cfd_out_buf (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  cfd_pkg::result_t  push_data,
    output logic              push_ready,
    output logic              out_valid,
    input  logic              out_ready,
    output cfd_pkg::result_t  out_data
);
    import cfd_pkg::*;

    logic    out_valid_reg;
    logic    skid_valid_reg;
    result_t out_data_reg;
    result_t skid_data_reg;
    logic    pop;

    assign pop        = out_valid_reg && out_ready;
    assign push_ready = !skid_valid_reg;
    assign out_valid  = out_valid_reg;
    assign out_data   = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            // no push is possible while the skid slot holds a result
            if (pop)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (push)
        begin
            if (!out_valid_reg || pop)
            begin
                out_valid_reg <= 1'b1;
            end
            else
            begin
                skid_valid_reg <= 1'b1;
            end
        end
        else if (pop)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (pop)
            begin
                out_data_reg <= skid_data_reg;
            end
        end
        else if (push)
        begin
            if (!out_valid_reg || pop)
            begin
                out_data_reg <= push_data;
            end
            else
            begin
                skid_data_reg <= push_data;
            end
        end
    end

endmodule

[hdl/checksummed_frame_deframer.sv]
// A frame's result is registered into the output buffer's result register, or into its skid slot while that is stalled.
// Throughput: one received byte per cycle while rx.ready is high; the parser state is registered on each accepted byte.
// rx.ready drops only while both the result register and the skid slot hold results.
// Reset (rst_n low, asynchronous): parser waits for a header, output slots empty,
// device_address = 0x10 and address_check = 0xEF.
module checksummed_frame_deframer #(
    parameter int DECODED_BYTES = 15
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [cfd_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [7:0]                      cfg_data,
    cfd_rx_if.sink                          rx,
    cfd_frame_if.source                     frame
);
    import cfd_pkg::*;

    cfg_t    cfg_reg;
    logic    accept;
    logic    result_valid;
    result_t result;
    result_t out_data;
    logic    push_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.device_address <= DEVICE_ADDRESS_RST;
            cfg_reg.address_check  <= ADDRESS_CHECK_RST;
        end
        else if (cfg_we)
        begin
            if (cfg_index == REG_DEVICE_ADDRESS)
            begin
                cfg_reg.device_address <= cfg_data;
            end
            else if (cfg_index == REG_ADDRESS_CHECK)
            begin
                cfg_reg.address_check <= cfg_data;
            end
        end
    end

    assign rx.ready = push_ready;
    assign accept   = rx.valid && push_ready;

    cfd_parser #(
        .DECODED_BYTES (DECODED_BYTES)
    ) u_parser (
        .clk          (clk),
        .rst_n        (rst_n),
        .byte_valid   (accept),
        .byte_data    (rx.rx_byte),
        .cfg          (cfg_reg),
        .result_valid (result_valid),
        .result       (result)
    );

    cfd_out_buf u_out_buf (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (result_valid),
        .push_data  (result),
        .push_ready (push_ready),
        .out_valid  (frame.valid),
        .out_ready  (frame.ready),
        .out_data   (out_data)
    );

    assign frame.frame_kind     = out_data.frame_kind;
    assign frame.command_code   = out_data.command_code;
    assign frame.payload_length = out_data.payload_length;
    assign frame.data_low       = out_data.data_low;
    assign frame.data_high      = out_data.data_high;

endmodule

[hdl/cfd_checker.sv]
// Port-level assertions for the checksummed frame deframer, with its bind.
module cfd_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        rx_valid,
    input logic        rx_ready,
    input logic [7:0]  rx_byte,
    input logic        out_valid,
    input logic        out_ready,
    input logic [2:0]  frame_kind,
    input logic [7:0]  command_code,
    input logic [63:0] data_low
);
    import cfd_pkg::*;

    // A stalled result transaction stays offered.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    // A new result only follows an accepted end byte.
    a_rise_after_end: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(rx_valid && rx_ready && rx_byte == END_BYTE))
        else $error("result appeared without an end byte");

    // The kind must agree with the command code.
    a_kind_match: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> frame_kind == kind_of(command_code))
        else $error("frame kind does not match command");

    // Input is refused only while a result is waiting on the output.
    a_ready_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        !rx_ready |-> out_valid && $past(out_valid && !out_ready))
        else $error("input refused with output free");

    // A stalled result transaction keeps its payload.
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(command_code) && $stable(data_low))
        else $error("stalled result payload changed");

endmodule

bind checksummed_frame_deframer cfd_checker u_cfd_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .rx_valid     (rx.valid),
    .rx_ready     (rx.ready),
    .rx_byte      (rx.rx_byte),
    .out_valid    (frame.valid),
    .out_ready    (frame.ready),
    .frame_kind   (frame.frame_kind),
    .command_code (frame.command_code),
    .data_low     (frame.data_low)
);

[tb/checksummed_frame_deframer_tb.sv]
// Self-checking testbench for the checksummed frame deframer: byte stream in, decoded frames out.
module checksummed_frame_deframer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import cfd_pkg::*;

    localparam int DECODED      = 15;
    localparam int IDLE_PCT     = 16;
    localparam int PHASE_BYTES  = 250;
    localparam int PHASES       = 7;
    localparam int HOLD_CYCLES  = 300;
    localparam int QUIET_LIMIT  = 2000;
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE = 8'd2;

    typedef enum logic [2:0] {
        P_HUNT, P_ADDR, P_CHECK, P_CMD, P_LEN, P_BODY, P_SUM, P_TRAILER
    } hunt_t;

    // A plain byte, or the checksum worked out at send time, correct or corrupted.
    typedef enum logic [1:0] { TOK_BYTE, TOK_GOOD_SUM, TOK_BAD_SUM } tok_t;

    typedef struct {
        tok_t       tok;
        logic [7:0] value;
        bit         typed;
        result_t    want;
    } row_t;

    // An unwritten staging byte decodes as 0x00 - 0x33 = 0xCD.
    localparam result_t WANT_EMPTY_NORMAL =
        {KIND_NORMAL, CMD_NORMAL, 8'h00, {8{8'hCD}}, {7{8'hCD}}};
    localparam result_t WANT_ONE_BYTE_UNKNOWN =
        {KIND_ERROR, 8'hFF, 8'h01, {{7{8'hCD}}, 8'hCC}, {7{8'hCD}}};

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [7:0] cfg_data;

    cfd_rx_if    rx_bus();
    cfd_frame_if frame_bus();

    checksummed_frame_deframer #(.DECODED_BYTES(DECODED)) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .rx        (rx_bus),
        .frame     (frame_bus)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Parser mirror
    hunt_t      hunt_phase   = P_HUNT;
    bit         addr_matched = 1'b0;
    logic [7:0] sum_acc      = 8'h00;
    logic [7:0] len_reg      = 8'h00;
    logic [7:0] body_count   = 8'h00;
    logic [7:0] cmd_reg      = 8'h00;
    logic [7:0] stage [STAGE_SLOTS] = '{default: 8'h00};
    logic [7:0] cfg_addr     = DEVICE_ADDRESS_RST;
    logic [7:0] cfg_check    = ADDRESS_CHECK_RST;

    result_t frames_due [$];
    row_t    burst [$];
    int      mismatches   = 0;
    int      bytes_sent   = 0;
    int      quiet_cycles = 0;
    bit      calm         = 1'b0;
    bit      hold_request = 1'b0;

    row_t directed_rows [30] = '{
        // zero-length normal data frame
        '{TOK_BYTE, HDR_BYTE, 1'b0, '0}, '{TOK_BYTE, DEVICE_ADDRESS_RST, 1'b0, '0},
        '{TOK_BYTE, ADDRESS_CHECK_RST, 1'b0, '0}, '{TOK_BYTE, HDR_BYTE, 1'b0, '0},
        '{TOK_BYTE, CMD_NORMAL, 1'b0, '0}, '{TOK_BYTE, 8'h00, 1'b0, '0},
        '{TOK_GOOD_SUM, 8'h00, 1'b0, '0}, '{TOK_BYTE, END_BYTE, 1'b1, WANT_EMPTY_NORMAL},
        // unknown command, one payload byte at the top of the range
        '{TOK_BYTE, HDR_BYTE, 1'b0, '0}, '{TOK_BYTE, DEVICE_ADDRESS_RST, 1'b0, '0},
        '{TOK_BYTE, ADDRESS_CHECK_RST, 1'b0, '0}, '{TOK_BYTE, HDR_BYTE, 1'b0, '0},
        '{TOK_BYTE, 8'hFF, 1'b0, '0}, '{TOK_BYTE, 8'h01, 1'b0, '0},
        '{TOK_BYTE, 8'hFF, 1'b0, '0}, '{TOK_GOOD_SUM, 8'h00, 1'b0, '0},
        '{TOK_BYTE, END_BYTE, 1'b1, WANT_ONE_BYTE_UNKNOWN},
        // address seen, then a non-header byte must clear the flag;
        // the next header starts a fresh frame and a wrong address drops it
        '{TOK_BYTE, HDR_BYTE, 1'b0, '0}, '{TOK_BYTE, DEVICE_ADDRESS_RST, 1'b0, '0},
        '{TOK_BYTE, ADDRESS_CHECK_RST, 1'b0, '0}, '{TOK_BYTE, 8'h00, 1'b0, '0},
        '{TOK_BYTE, HDR_BYTE, 1'b0, '0}, '{TOK_BYTE, 8'h11, 1'b0, '0},
        // reset command with a corrupted checksum
        '{TOK_BYTE, HDR_BYTE, 1'b0, '0}, '{TOK_BYTE, DEVICE_ADDRESS_RST, 1'b0, '0},
        '{TOK_BYTE, ADDRESS_CHECK_RST, 1'b0, '0}, '{TOK_BYTE, HDR_BYTE, 1'b0, '0},
        '{TOK_BYTE, CMD_RESET, 1'b0, '0}, '{TOK_BYTE, 8'h00, 1'b0, '0},
        '{TOK_BAD_SUM, 8'h00, 1'b0, '0}
    };

    function automatic kind_t kind_for_command(input logic [7:0] cmd);
        case (cmd)
            CMD_NORMAL: return KIND_NORMAL;
            CMD_INFO:   return KIND_INFO;
            CMD_TEST:   return KIND_TEST;
            CMD_RESET:  return KIND_RESET;
            default:    return KIND_ERROR;
        endcase
    endfunction

    // Advance the parser mirror by one byte; return 1 when a frame completes.
    function automatic bit parse_byte(input logic [7:0] b, output result_t r);
        bit produced;
        logic [7:0] d;
        produced = 1'b0;
        r = '0;
        case (hunt_phase)
            P_HUNT:
                if (b == HDR_BYTE) begin
                    if (addr_matched) begin
                        addr_matched = 1'b0;
                        sum_acc += b;
                        hunt_phase = P_CMD;
                    end
                    else begin
                        foreach (stage[k]) stage[k] = 8'h00;
                        sum_acc = b;
                        hunt_phase = P_ADDR;
                    end
                end
                else begin
                    addr_matched = 1'b0;
                end
            P_ADDR:
                if (b == cfg_addr) begin
                    sum_acc += b;
                    hunt_phase = P_CHECK;
                end
                else begin
                    hunt_phase = P_HUNT;
                end
            P_CHECK:
            begin
                if (b == cfg_check) begin
                    sum_acc += b;
                    addr_matched = 1'b1;
                end
                else begin
                    addr_matched = 1'b0;
                end
                hunt_phase = P_HUNT;
            end
            P_CMD:
            begin
                cmd_reg = b;
                sum_acc += b;
                hunt_phase = P_LEN;
            end
            P_LEN:
            begin
                len_reg = b;
                body_count = 8'h00;
                sum_acc += b;
                hunt_phase = (b == 8'h00) ? P_SUM : P_BODY;
            end
            P_BODY:
            begin
                if (body_count < DECODED && body_count < STAGE_SLOTS)
                    stage[body_count] = b;
                sum_acc += b;
                body_count += 8'd1;
                if (body_count == len_reg) begin
                    body_count = 8'h00;
                    hunt_phase = P_SUM;
                end
            end
            P_SUM:
                hunt_phase = (b == sum_acc) ? P_TRAILER : P_HUNT;
            default:
            begin
                hunt_phase = P_HUNT;
                if (b == END_BYTE) begin
                    produced = 1'b1;
                    r.frame_kind = kind_for_command(cmd_reg);
                    r.command_code = cmd_reg;
                    r.payload_length = len_reg;
                    for (int k = 0; k < STAGE_SLOTS; k++) begin
                        d = (k < DECODED) ? stage[k] - DECODE_OFFSET : 8'h00;
                        if (k < 8)
                            r.data_low[8*k +: 8] = d;
                        else
                            r.data_high[8*(k-8) +: 8] = d;
                    end
                end
            end
        endcase
        return produced;
    endfunction

    function automatic void put(input tok_t t, input logic [7:0] v);
        burst.push_back('{t, v, 1'b0, '0});
    endfunction

    // Mostly well-formed frames with random content; the rest broken or noise.
    function automatic void plan_random_burst();
        int pick;
        int len;
        logic [7:0] b;
        pick = $urandom_range(99);
        if (pick >= 95) begin
            repeat ($urandom_range(4, 1)) put(TOK_BYTE, 8'($urandom));
            return;
        end
        put(TOK_BYTE, HDR_BYTE);
        if (pick >= 90) begin
            if ($urandom_range(1) == 1) begin
                put(TOK_BYTE, cfg_addr ^ 8'($urandom_range(255, 1)));
            end
            else begin
                put(TOK_BYTE, cfg_addr);
                put(TOK_BYTE, cfg_check ^ 8'($urandom_range(255, 1)));
            end
            return;
        end
        put(TOK_BYTE, cfg_addr);
        put(TOK_BYTE, cfg_check);
        if (pick >= 84) begin
            // break the sequence after the address, then either stop or restart cleanly
            do b = 8'($urandom); while (b == HDR_BYTE);
            put(TOK_BYTE, b);
            if ($urandom_range(1) == 1)
                return;
            put(TOK_BYTE, HDR_BYTE);
            put(TOK_BYTE, cfg_addr);
            put(TOK_BYTE, cfg_check);
        end
        put(TOK_BYTE, HDR_BYTE);
        case ($urandom_range(4))
            0:       put(TOK_BYTE, CMD_NORMAL);
            1:       put(TOK_BYTE, CMD_INFO);
            2:       put(TOK_BYTE, CMD_TEST);
            3:       put(TOK_BYTE, CMD_RESET);
            default: put(TOK_BYTE, 8'($urandom));
        endcase
        len = $urandom_range(99);
        if (len < 10)
            len = 0;
        else if (len < 80)
            len = $urandom_range(15, 1);
        else if (len < 97)
            len = $urandom_range(40, 16);
        else
            len = $urandom_range(255, 41);
        put(TOK_BYTE, 8'(len));
        repeat (len) put(TOK_BYTE, 8'($urandom));
        put((pick >= 78 && pick < 84) ? TOK_BAD_SUM : TOK_GOOD_SUM, 8'h00);
        if (pick >= 70 && pick < 78)
            put(TOK_BYTE, END_BYTE ^ 8'($urandom_range(255, 1)));
        else
            put(TOK_BYTE, END_BYTE);
    endfunction

    // Called at a falling edge; returns at the falling edge after the transaction.
    task automatic send_token(input row_t row);
        logic [7:0] b;
        result_t predicted;
        bit done;
        while (!calm && $urandom_range(99) < IDLE_PCT) begin
            rx_bus.valid <= 1'b0;
            @(negedge clk);
        end
        case (row.tok)
            TOK_GOOD_SUM: b = sum_acc;
            TOK_BAD_SUM:  b = sum_acc ^ 8'($urandom_range(255, 1));
            default:      b = row.value;
        endcase
        rx_bus.valid   <= 1'b1;
        rx_bus.rx_byte <= b;
        @(posedge clk);
        while (!rx_bus.ready) @(posedge clk);
        bytes_sent++;
        done = parse_byte(b, predicted);
        if (row.typed)
            frames_due.push_back(row.want);
        else if (done)
            frames_due.push_back(predicted);
        @(negedge clk);
    endtask

    // Receiver: random stalls, a long hold-off on request, none while calm.
    initial
    begin
        int hold_left;
        hold_left = 0;
        forever begin
            @(negedge clk);
            if (hold_request) begin
                hold_request = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                frame_bus.ready <= 1'b0;
            end
            else begin
                frame_bus.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    always @(posedge clk)
    begin
        result_t got;
        result_t want;
        if (rst_n && frame_bus.valid && frame_bus.ready) begin
            got = {frame_bus.frame_kind, frame_bus.command_code, frame_bus.payload_length,
                   frame_bus.data_low, frame_bus.data_high};
            if (frames_due.size() == 0) begin
                mismatches++;
                $display("%0t: frame with none expected, command %h length %0d",
                         $time, got.command_code, got.payload_length);
            end
            else begin
                want = frames_due.pop_front();
                if (got.frame_kind != want.frame_kind) begin
                    mismatches++;
                    $display("%0t: frame_kind expected %0d got %0d",
                             $time, want.frame_kind, got.frame_kind);
                end
                if (got.command_code != want.command_code) begin
                    mismatches++;
                    $display("%0t: command_code expected %h got %h",
                             $time, want.command_code, got.command_code);
                end
                if (got.payload_length != want.payload_length) begin
                    mismatches++;
                    $display("%0t: payload_length expected %h got %h",
                             $time, want.payload_length, got.payload_length);
                end
                if (got.data_low != want.data_low) begin
                    mismatches++;
                    $display("%0t: data_low expected %h got %h",
                             $time, want.data_low, got.data_low);
                end
                if (got.data_high != want.data_high) begin
                    mismatches++;
                    $display("%0t: data_high expected %h got %h",
                             $time, want.data_high, got.data_high);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((rx_bus.valid && rx_bus.ready) || (frame_bus.valid && frame_bus.ready)) begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("checksummed_frame_deframer test failed");
            $finish;
        end
        else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        int phase_end;
        logic [7:0] new_addr;
        logic [7:0] new_check;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = REG_DEVICE_ADDRESS;
        cfg_data = 8'h00;
        rx_bus.valid = 1'b0;
        rx_bus.rx_byte = 8'h00;
        frame_bus.ready = 1'b0;
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (directed_rows[i]) send_token(directed_rows[i]);

        for (int p = 0; p < PHASES; p++) begin
            // drain before touching the registers
            rx_bus.valid <= 1'b0;
            while (frames_due.size() != 0) @(posedge clk);
            repeat (4) @(posedge clk);
            @(negedge clk);
            case (p)
                0, 6:
                begin
                    new_addr = DEVICE_ADDRESS_RST;
                    new_check = ADDRESS_CHECK_RST;
                end
                1:
                begin
                    new_addr = 8'h00;
                    new_check = 8'hFF;
                end
                3:
                begin
                    new_addr = HDR_BYTE;
                    new_check = HDR_BYTE;
                end
                4:
                begin
                    new_addr = 8'hFF;
                    new_check = 8'h00;
                end
                default:
                begin
                    new_addr = 8'($urandom);
                    new_check = 8'($urandom);
                end
            endcase
            cfg_we <= 1'b1;
            cfg_index <= REG_DEVICE_ADDRESS;
            cfg_data <= new_addr;
            @(negedge clk);
            cfg_index <= REG_ADDRESS_CHECK;
            cfg_data <= new_check;
            @(negedge clk);
            if (p == 3) begin
                // out-of-range index must be ignored
                cfg_index <= REG_SPARE;
                cfg_data <= 8'($urandom);
                @(negedge clk);
            end
            cfg_we <= 1'b0;
            cfg_addr = new_addr;
            cfg_check = new_check;
            calm = (p == 5);
            if (p == 2)
                hold_request = 1'b1;

            phase_end = bytes_sent + PHASE_BYTES;
            while (bytes_sent < phase_end) begin
                plan_random_burst();
                foreach (burst[i]) send_token(burst[i]);
                burst.delete();
            end
        end

        rx_bus.valid <= 1'b0;
        while (frames_due.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("checksummed_frame_deframer test passed");
        else
            $display("checksummed_frame_deframer test failed");
        $finish;
    end

endmodule
